### rtl/bccfd_pkg.sv
// shared constants and types of the bcc frame deframer
`timescale 1ns / 1ps
`default_nettype none
package bccfd_pkg;

   localparam int BYTE_W        = 8;
   localparam int LEN_W         = 8;
   localparam int FRAME_LEN_W   = 7;
   localparam int MAX_FRAME_DEF = 64;

   localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h3A;
   localparam logic [BYTE_W-1:0] TAIL_BYTE   = 8'h23;
   localparam logic [LEN_W-1:0]  MIN_FRAME   = 8'd4;

   // receive side events: store write and end of frame
   typedef struct packed {
      logic              wr_en;
      logic [LEN_W-1:0]  wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              done;
      logic [LEN_W-1:0]  len;
   } bccfd_rx_evt_type;

endpackage
`default_nettype wire

### rtl/bccfd_if.sv
// valid/ready channel interfaces of the bcc frame deframer
`timescale 1ns / 1ps
`default_nettype none
interface bccfd_req_if;
   logic                         valid;
   logic                         ready;
   logic [bccfd_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface bccfd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [bccfd_pkg::BYTE_W-1:0]      frame_byte;
   logic                              frame_last;
   logic [bccfd_pkg::FRAME_LEN_W-1:0] frame_length;

   modport source (output valid, output frame_byte, output frame_last,
                   output frame_length, input ready);
   modport sink (input valid, input frame_byte, input frame_last,
                 input frame_length, output ready);
endinterface
`default_nettype wire

### rtl/bccfd_parser.sv
// receive parser: header hunt, length check, bcc and tail check
`timescale 1ns / 1ps
`default_nettype none
module bccfd_parser #(
   parameter int MAX_FRAME = bccfd_pkg::MAX_FRAME_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          byte_valid,
   input  wire logic [bccfd_pkg::BYTE_W-1:0]  byte_data,
   output bccfd_pkg::bccfd_rx_evt_type        evt
);
   import bccfd_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAME + 1);

   typedef enum logic [2:0] {
      ST_HUNT = 3'b001,
      ST_LEN  = 3'b010,
      ST_BODY = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [BYTE_W-1:0]  xor_ff, xor_in;
   logic [BYTE_W-1:0]  prev_ff, prev_in;
   logic [LEN_W-1:0]   count_ext;

   assign count_ext = LEN_W'(count_ff);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      len_in      = len_ff;
      xor_in      = xor_ff;
      prev_in     = prev_ff;
      evt         = '0;
      evt.wr_data = byte_data;
      evt.len     = len_ff;
      if (byte_valid) begin
         unique case (state_ff)
            ST_HUNT: begin
               if (byte_data == HEADER_BYTE) begin
                  evt.wr_en   = 1'b1;
                  evt.wr_addr = LEN_W'(0);
                  count_in    = CNT_W'(1);
                  xor_in      = byte_data;
                  state_in    = ST_LEN;
               end
            end
            ST_LEN: begin
               if (byte_data < MIN_FRAME || byte_data > LEN_W'(MAX_FRAME)) begin
                  state_in = ST_HUNT;
                  count_in = '0;
                  xor_in   = '0;
               end else begin
                  evt.wr_en   = 1'b1;
                  evt.wr_addr = LEN_W'(1);
                  len_in      = byte_data;
                  xor_in      = xor_ff ^ byte_data;
                  count_in    = CNT_W'(2);
                  state_in    = ST_BODY;
               end
            end
            ST_BODY: begin
               evt.wr_en   = 1'b1;
               evt.wr_addr = count_ext;
               prev_in     = byte_data;
               // bcc covers everything before the bcc byte itself
               if (count_ext < len_ff - LEN_W'(2)) begin
                  xor_in = xor_ff ^ byte_data;
               end
               if (count_ext + LEN_W'(1) == len_ff) begin
                  // byte before the tail holds the bcc
                  evt.done = (byte_data == TAIL_BYTE) && (prev_ff == xor_ff);
                  state_in = ST_HUNT;
                  count_in = '0;
                  xor_in   = '0;
                  len_in   = '0;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            default: begin
               state_in = ST_HUNT;
               count_in = '0;
               xor_in   = '0;
               len_in   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
         count_ff <= '0;
         len_ff   <= '0;
         xor_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         len_ff   <= len_in;
         xor_ff   <= xor_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
   end

endmodule
`default_nettype wire

### rtl/bcc_frame_deframer_top.sv
// top level of the bcc frame deframer: frame store and frame playback
// usage
//   req_if carries received bytes, one beat per byte, in valid/ready form
//   frames look like: header 0x3a, length L, payload, bcc, tail 0x23
//   L counts every byte from header to tail and must lie in 4..MAX_FRAME
//   bcc is the xor of all bytes before it; a frame failing any check is
//   dropped with no output and the header hunt restarts after it
//   rsp_if returns a good frame byte by byte, header first, frame_last on
//   the tail byte, frame_length carrying L on every beat
// timing
//   one input byte per cycle while receiving; the frame bytes are written
//   into a single-port-write, single-port-read store as they arrive
//   once the tail byte is taken, playback starts and the first output beat
//   is registered through the store read port, then one beat per cycle
//   follows as long as the receiver keeps ready high
//   req_if.ready is low while a frame is being played back, stalls included;
//   the last beat may still wait in the output register while reception
//   of the next frame goes on
// reset and stalls
//   synchronous reset returns to header hunt and empties the output
//   register; the store itself is not cleared
//   a stalled receiver holds the output beat, and store reads pause with it
`timescale 1ns / 1ps
`default_nettype none
module bcc_frame_deframer_top #(
   parameter int MAX_FRAME = bccfd_pkg::MAX_FRAME_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   bccfd_req_if.sink   req_if,
   bccfd_rsp_if.source rsp_if
);
   import bccfd_pkg::*;

   localparam int ADDR_W = $clog2(MAX_FRAME);
   localparam int CNT_W  = $clog2(MAX_FRAME + 1);

   // frame store, written by the parser and read back for playback
   logic [BYTE_W-1:0]      frame_store_ff [MAX_FRAME];
   logic [BYTE_W-1:0]      rd_data_ff;

   bccfd_rx_evt_type       evt;
   logic                   byte_take;

   // playback control
   logic                   emitting_ff, emitting_in;
   logic [CNT_W-1:0]       emit_idx_ff, emit_idx_in;
   logic [LEN_W-1:0]       emit_len_ff, emit_len_in;
   logic                   slot_free;
   logic                   issue;
   logic                   issue_last;

   // output register state (byte itself sits in the store read register)
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [FRAME_LEN_W-1:0] rsp_len_ff, rsp_len_in;

   assign req_if.ready = !emitting_ff;
   assign byte_take    = req_if.valid && !emitting_ff;

   bccfd_parser #(
      .MAX_FRAME (MAX_FRAME)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_take),
      .byte_data  (req_if.rx_byte),
      .evt        (evt)
   );

   // read a new byte only when the output register frees up
   assign slot_free  = !rsp_valid_ff || rsp_if.ready;
   assign issue      = emitting_ff && slot_free;
   assign issue_last = (LEN_W'(emit_idx_ff) + LEN_W'(1)) == emit_len_ff;

   always_comb begin
      emitting_in  = emitting_ff;
      emit_idx_in  = emit_idx_ff;
      emit_len_in  = emit_len_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (evt.done) begin
         emitting_in = 1'b1;
         emit_idx_in = '0;
         emit_len_in = evt.len;
      end else if (issue) begin
         emit_idx_in  = emit_idx_ff + CNT_W'(1);
         rsp_valid_in = 1'b1;
         rsp_last_in  = issue_last;
         rsp_len_in   = emit_len_ff[FRAME_LEN_W-1:0];
         if (issue_last) begin
            emitting_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emitting_ff  <= 1'b0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         emitting_ff  <= emitting_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      emit_len_ff <= emit_len_in;
      rsp_last_ff <= rsp_last_in;
      rsp_len_ff  <= rsp_len_in;
   end

   // store write port: only while receiving
   always_ff @(posedge clock) begin
      if (evt.wr_en) begin
         frame_store_ff[evt.wr_addr[ADDR_W-1:0]] <= evt.wr_data;
      end
   end

   // store read port: registered, holds while the receiver stalls
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= frame_store_ff[emit_idx_ff[ADDR_W-1:0]];
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.frame_byte   = rd_data_ff;
   assign rsp_if.frame_last   = rsp_last_ff;
   assign rsp_if.frame_length = rsp_len_ff;

endmodule
`default_nettype wire

### sim/bcc_frame_deframer_top_tb.sv
// self-checking testbench of the bcc frame deframer: framed byte stream in, frame beats checked
`timescale 1ns / 1ps
module bcc_frame_deframer_top_tb;
   import bccfd_pkg::*;

   localparam int FRAME_MAX     = MAX_FRAME_DEF;
   // generous watchdog limit
   localparam int CYCLE_LIMIT   = 200000;
   // one full-size frame played back, with margin for stalls
   localparam int SETTLE_CYCLES = 2 * FRAME_MAX + 20;
   localparam int RANDOM_BYTES  = 75;
   localparam int IDLE_PERCENT  = 16;

   // receive side of the deframer as the predictor tracks it
   typedef enum logic [1:0] {SEEK_HEADER, SEEK_LENGTH, SEEK_BODY} deframe_state_t;
   // how a generated frame is damaged, if at all
   typedef enum int {FRAME_GOOD, FRAME_BAD_BCC, FRAME_BAD_TAIL} frame_fault_t;

   typedef struct packed {
      logic [BYTE_W-1:0]      data;
      logic                   last;
      logic [FRAME_LEN_W-1:0] length;
   } frame_beat_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bccfd_req_if req_ch ();
   bccfd_rsp_if rsp_ch ();

   bcc_frame_deframer_top #(
      .MAX_FRAME(FRAME_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   always #4 clock = ~clock;

   // predictor state: a copy of the frame being received
   deframe_state_t    seek_state  = SEEK_HEADER;
   logic [BYTE_W-1:0] frame_copy [FRAME_MAX];
   int unsigned       copy_count  = 0;
   int unsigned       copy_length = 0;
   logic [BYTE_W-1:0] copy_bcc    = '0;

   // bytes still to send, and frame beats still to arrive
   logic [BYTE_W-1:0] rx_pending [$];
   frame_beat_t       frame_beats_due [$];

   int bytes_queued = 0;
   int bytes_taken  = 0;
   int beats_seen   = 0;
   int fail_count   = 0;
   int cycle_count  = 0;

   // long stretches where the sender, or the receiver, does not idle
   wire sender_quiet   = bytes_taken >= 100 && bytes_taken < 180;
   wire receiver_quiet = beats_seen >= 60 && beats_seen < 160;

   // advance the predictor by one received byte; a frame that passes both
   // checks queues all its bytes as expected beats
   function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
      frame_beat_t beat;
      case (seek_state)
         SEEK_LENGTH: begin
            // length outside 4..max drops the frame at its length byte
            if (b < MIN_FRAME || b > FRAME_MAX) begin
               seek_state = SEEK_HEADER;
            end else begin
               copy_length   = b;
               frame_copy[1] = b;
               copy_bcc      = copy_bcc ^ b;
               copy_count    = 2;
               seek_state    = SEEK_BODY;
            end
         end
         SEEK_BODY: begin
            // the bcc covers everything before the bcc byte itself
            if (copy_count < copy_length - 2) copy_bcc = copy_bcc ^ b;
            frame_copy[copy_count] = b;
            copy_count++;
            if (copy_count == copy_length) begin
               if (frame_copy[copy_length-1] == TAIL_BYTE &&
                   frame_copy[copy_length-2] == copy_bcc) begin
                  for (int k = 0; k < copy_length; k++) begin
                     beat.data   = frame_copy[k];
                     beat.last   = (k == copy_length - 1);
                     beat.length = copy_length[FRAME_LEN_W-1:0];
                     frame_beats_due.push_back(beat);
                  end
               end
               // good or bad, the hunt restarts after the whole frame
               seek_state = SEEK_HEADER;
            end
         end
         default: begin
            // anything but a header is discarded while hunting
            if (b == HEADER_BYTE) begin
               frame_copy[0] = b;
               copy_count    = 1;
               copy_bcc      = b;
               seek_state    = SEEK_LENGTH;
            end else begin
               seek_state = SEEK_HEADER;
            end
         end
      endcase
   endfunction

   function automatic void queue_byte(input logic [BYTE_W-1:0] b);
      rx_pending.push_back(b);
      bytes_queued++;
   endfunction

   // one complete frame of len bytes with random payload, optionally damaged
   function automatic void queue_frame(input int unsigned len, input frame_fault_t fault);
      logic [BYTE_W-1:0] bcc;
      logic [BYTE_W-1:0] body;
      bcc = HEADER_BYTE ^ len[BYTE_W-1:0];
      queue_byte(HEADER_BYTE);
      queue_byte(len[BYTE_W-1:0]);
      for (int k = 2; k < len - 2; k++) begin
         body = 8'($urandom_range(0, 255));
         bcc  = bcc ^ body;
         queue_byte(body);
      end
      if (fault == FRAME_BAD_BCC) bcc = bcc ^ 8'(1 << $urandom_range(0, 7));
      queue_byte(bcc);
      if (fault == FRAME_BAD_TAIL) begin
         queue_byte(TAIL_BYTE ^ 8'($urandom_range(1, 255)));
      end else begin
         queue_byte(TAIL_BYTE);
      end
   endfunction

   // mostly well-formed frames with random content, the rest damaged frames,
   // bad lengths, cut-off frames and line noise
   task automatic queue_random_traffic(input int amount);
      int          stop_at;
      int unsigned pick;
      int unsigned len;
      stop_at = bytes_queued + amount;
      while (bytes_queued < stop_at) begin
         pick = $urandom_range(0, 99);
         // mostly short frames, now and then a long one
         if ($urandom_range(0, 99) < 5) begin
            len = $urandom_range(13, FRAME_MAX);
         end else begin
            len = $urandom_range(MIN_FRAME, 12);
         end
         if (pick < 66) begin
            queue_frame(len, FRAME_GOOD);
         end else if (pick < 74) begin
            queue_frame(len, FRAME_BAD_BCC);
         end else if (pick < 82) begin
            queue_frame(len, FRAME_BAD_TAIL);
         end else if (pick < 89) begin
            // length byte out of range
            queue_byte(HEADER_BYTE);
            if ($urandom_range(0, 1) == 0) begin
               queue_byte(8'($urandom_range(0, MIN_FRAME - 1)));
            end else begin
               queue_byte(8'($urandom_range(FRAME_MAX + 1, 255)));
            end
         end else if (pick < 94) begin
            // frame cut short: whatever follows is taken as its body
            queue_byte(HEADER_BYTE);
            queue_byte(len[BYTE_W-1:0]);
            repeat ($urandom_range(0, len - MIN_FRAME)) queue_byte(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // sender holds off until every byte is taken and every beat has come back
   task automatic wait_for_drain();
      while (rx_pending.size() != 0 || req_ch.valid || frame_beats_due.size() != 0)
         @(posedge clock);
   endtask

   // byte driver: a beat taken at this edge feeds the predictor, then the
   // next byte is offered unless this cycle idles
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.rx_byte <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            deframe_byte(req_ch.rx_byte);
            bytes_taken++;
         end
         if (rx_pending.size() != 0 &&
             (sender_quiet || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            req_ch.valid   <= 1'b1;
            req_ch.rx_byte <= rx_pending.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // frame beat monitor: each beat taken is checked against the oldest
   // expected beat; ready drops at random to stall playback
   always @(posedge clock) begin
      frame_beat_t due;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            beats_seen++;
            if (frame_beats_due.size() == 0) begin
               $display("%0t: unexpected frame beat: byte %h last %b length %0d",
                        $time, rsp_ch.frame_byte, rsp_ch.frame_last, rsp_ch.frame_length);
               fail_count++;
            end else begin
               due = frame_beats_due.pop_front();
               if (rsp_ch.frame_byte !== due.data || rsp_ch.frame_last !== due.last ||
                   rsp_ch.frame_length !== due.length) begin
                  $display("%0t: frame beat mismatch: expected byte %h last %b length %0d, %s",
                           $time, due.data, due.last, due.length,
                           $sformatf("got byte %h last %b length %0d", rsp_ch.frame_byte,
                                     rsp_ch.frame_last, rsp_ch.frame_length));
                  fail_count++;
               end
            end
         end
         rsp_ch.ready <= receiver_quiet || $urandom_range(0, 99) >= IDLE_PERCENT;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      rsp_ch.ready   = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // queue changes happen away from the active edge
      @(negedge clock);

      // directed: noise with all bits low and high while hunting
      queue_byte(8'h00);
      queue_byte(8'hFF);
      // length just below the minimum, just above the store, and all ones
      queue_byte(HEADER_BYTE);
      queue_byte(8'd3);
      queue_byte(HEADER_BYTE);
      queue_byte(8'(FRAME_MAX + 1));
      queue_byte(HEADER_BYTE);
      queue_byte(8'hFF);
      // shortest good frame, then the same with a bad bcc and a bad tail
      queue_frame(MIN_FRAME, FRAME_GOOD);
      queue_frame(MIN_FRAME, FRAME_BAD_BCC);
      queue_frame(MIN_FRAME, FRAME_BAD_TAIL);
      // frame with one payload byte after a damaged one
      queue_frame(5, FRAME_GOOD);
      wait_for_drain();
      @(negedge clock);

      // first random half opens with a full-size frame
      queue_frame(FRAME_MAX, FRAME_GOOD);
      queue_random_traffic(RANDOM_BYTES);
      wait_for_drain();
      @(negedge clock);

      // second half opens with a full-size frame that fails its bcc
      queue_frame(FRAME_MAX, FRAME_BAD_BCC);
      queue_random_traffic(RANDOM_BYTES);
      wait_for_drain();

      // let any stray beat show up before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (frame_beats_due.size() != 0) begin
         $display("%0t: %0d expected frame beats never arrived", $time, frame_beats_due.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
